// ===== hdl/fesd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesd_pkg
// Shared types and constants of the FLV elementary stream demultiplexer.
// ----------------------------------------------------------------------------
package fesd_pkg;

	localparam int MaxRes = 7;
	localparam int CntW   = $clog2(MaxRes + 1);
	localparam int IdxW   = $clog2(MaxRes);

	localparam logic [7:0] SigF = 8'h46;
	localparam logic [7:0] SigL = 8'h4C;
	localparam logic [7:0] SigV = 8'h56;

	localparam logic [7:0] TagAudio = 8'd8;
	localparam logic [7:0] TagVideo = 8'd9;
	localparam logic [3:0] FmtAac   = 4'd10;
	localparam logic [3:0] CodecAvc = 4'd7;

	localparam logic [7:0]  AdtsSync0 = 8'hFF;
	localparam logic [7:0]  AdtsSync1 = 8'hF1;
	localparam logic [10:0] AdtsFull  = 11'h7FF;

	// results caused by one input byte, all of one stream
	typedef struct packed {
		logic [MaxRes-1:0][7:0] bytes;
		logic [CntW-1:0]        count;
		logic                   stream;
		logic                   error;
	} res_t;

endpackage

// ===== hdl/fesd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesd_parser
// FLV container parser: state registers and the per-byte result generation.
// ----------------------------------------------------------------------------
module fesd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_take,
	input  logic [7:0]         in_byte,
	output fesd_pkg::res_t     res
);

	typedef enum logic [4:0] {
		PH_SIG0, PH_SIG1, PH_SIG2, PH_FHDR, PH_THDR, PH_FIRST, PH_A_TYPE, PH_A_ASC,
		PH_A_RAW, PH_V_TYPE, PH_V_CT_SEQ, PH_V_CT_NAL, PH_SEQ_FIX, PH_SPS_BODY,
		PH_PPS_CNT, PH_PPS_HI, PH_PPS_LO, PH_PPS_BODY, PH_NAL_FIRST, PH_NAL_MORE,
		PH_NAL_BODY, PH_V_RAW, PH_SKIP, PH_DEAD
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [23:0] tbc_q, tbc_d;
	logic [7:0]  kind_q, kind_d;
	logic [23:0] psize_q, psize_d;
	logic        aon_q, aon_d, von_q, von_d;
	logic [5:0][7:0] asc_q, asc_d;
	logic [2:0]  nsb_q, nsb_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] run_q, run_d;

	logic [23:0] tbc_inc;
	logic [23:0] pos_m2;
	logic [23:0] remain;
	logic [31:0] run_dec;
	logic [31:0] nal_len;
	logic        nal_done;
	logic [6:0][7:0] adts;

	function automatic logic [6:0][7:0] adts_hdr(input logic [5:0][7:0] e,
			input logic [23:0] psize);
		logic [5:0]  obj;
		logic [3:0]  sr;
		logic [3:0]  ch;
		logic [1:0]  prof;
		logic [12:0] len;
		logic [6:0][7:0] h;
		if (e[0][7:3] == 5'h1F) begin
			obj = 6'(6'd32 + {e[0][2:0], e[1][7:5]});
			sr  = e[1][4:1];
			if (sr == 4'hF) ch = {e[4][0], e[5][7:5]};
			else ch = {e[1][0], e[2][7:5]};
		end else begin
			obj = {1'b0, e[0][7:3]};
			sr  = {e[0][2:0], e[1][7]};
			if (sr == 4'hF) ch = e[4][6:3];
			else ch = e[1][6:3];
		end
		prof = 2'(obj + 6'd3);
		len  = 13'(psize + 24'd5);
		h[0] = fesd_pkg::AdtsSync0;
		h[1] = fesd_pkg::AdtsSync1;
		h[2] = {prof, sr, 1'b0, ch[2]};
		h[3] = {ch[1:0], 4'b0, len[12:11]};
		h[4] = len[10:3];
		h[5] = {len[2:0], fesd_pkg::AdtsFull[10:6]};
		h[6] = {fesd_pkg::AdtsFull[5:0], 2'b00};
		return h;
	endfunction

	assign tbc_inc = tbc_q + 24'd1;
	assign pos_m2  = tbc_q - 24'd2;
	assign remain  = psize_q - tbc_q;
	assign run_dec = run_q - 32'd1;
	assign adts    = adts_hdr(asc_q, psize_q);

	always_comb begin
		phase_d = phase_q;
		tbc_d   = tbc_q;
		kind_d  = kind_q;
		psize_d = psize_q;
		aon_d   = aon_q;
		von_d   = von_q;
		asc_d   = asc_q;
		nsb_d   = nsb_q;
		acc_d   = acc_q;
		run_d   = run_q;
		nal_done = 1'b0;
		nal_len  = acc_q;
		res = '0;

		case (phase_q)
			PH_SIG0, PH_SIG1, PH_SIG2: begin
				if ((phase_q == PH_SIG0 && in_byte != fesd_pkg::SigF) ||
						(phase_q == PH_SIG1 && in_byte != fesd_pkg::SigL) ||
						(phase_q == PH_SIG2 && in_byte != fesd_pkg::SigV)) begin
					res.count = fesd_pkg::CntW'(1);
					res.error = 1'b1;
					phase_d = PH_DEAD;
				end else begin
					phase_d = phase_t'(phase_q + 5'd1);
					tbc_d   = {19'd0, phase_q + 5'd1};
				end
			end
			PH_FHDR: begin
				if (tbc_q == 24'd4) begin
					aon_d = in_byte[2];
					von_d = in_byte[0];
				end
				tbc_d = tbc_inc;
				if (tbc_inc >= 24'd9) begin
					tbc_d = '0;
					phase_d = PH_THDR;
				end
			end
			PH_THDR: begin
				if (tbc_q == 24'd4) kind_d = in_byte;
				else if (tbc_q == 24'd5) psize_d = {16'd0, in_byte};
				else if (tbc_q == 24'd6 || tbc_q == 24'd7) psize_d = {psize_q[15:0], in_byte};
				tbc_d = tbc_inc;
				if (tbc_inc >= 24'd15) begin
					tbc_d = '0;
					phase_d = (psize_d != '0) ? PH_FIRST : PH_THDR;
				end
			end
			PH_DEAD: ;
			default: begin
				res.stream = 1'b1;
				case (phase_q)
					PH_FIRST: begin
						if (kind_q == fesd_pkg::TagAudio)
							phase_d = (in_byte[7:4] == fesd_pkg::FmtAac) ? PH_A_TYPE : PH_SKIP;
						else if (kind_q == fesd_pkg::TagVideo)
							phase_d = (in_byte[3:0] == fesd_pkg::CodecAvc) ? PH_V_TYPE : PH_V_RAW;
						else phase_d = PH_SKIP;
					end
					PH_A_TYPE: begin
						res.stream = 1'b0;
						if (in_byte == 8'd0) begin
							asc_d = '0;
							phase_d = PH_A_ASC;
						end else if (aon_q) begin
							res.bytes = adts;
							res.count = fesd_pkg::CntW'(7);
							phase_d = PH_A_RAW;
						end else phase_d = PH_SKIP;
					end
					PH_A_ASC: begin
						if (pos_m2 < 24'd6) asc_d[pos_m2[2:0]] = in_byte;
					end
					PH_A_RAW: begin
						res.stream = 1'b0;
						res.bytes[0] = in_byte;
						res.count = fesd_pkg::CntW'(1);
					end
					PH_V_TYPE: begin
						if (in_byte == 8'd0) phase_d = PH_V_CT_SEQ;
						else if (in_byte == 8'd1 && von_q) phase_d = PH_V_CT_NAL;
						else phase_d = PH_SKIP;
					end
					PH_V_CT_SEQ: if (tbc_q >= 24'd4) phase_d = PH_SEQ_FIX;
					PH_V_CT_NAL: if (tbc_q >= 24'd4) phase_d = PH_NAL_FIRST;
					PH_SEQ_FIX: begin
						if (tbc_q == 24'd9) nsb_d = {1'b0, in_byte[1:0]} + 3'd1;
						else if (tbc_q == 24'd11) acc_d = {24'd0, in_byte};
						else if (tbc_q == 24'd12) begin
							acc_d = {16'd0, acc_q[7:0], in_byte};
							res.bytes[3] = 8'd1;
							res.count = von_q ? fesd_pkg::CntW'(4) : '0;
							run_d = acc_d;
							phase_d = (acc_d != '0) ? PH_SPS_BODY : PH_PPS_CNT;
						end
					end
					PH_SPS_BODY, PH_PPS_BODY, PH_NAL_BODY: begin
						res.bytes[0] = in_byte;
						res.count = fesd_pkg::CntW'(von_q);
						run_d = run_dec;
						if (run_dec == '0)
							phase_d = (phase_q == PH_SPS_BODY) ? PH_PPS_CNT :
								(phase_q == PH_PPS_BODY) ? PH_SKIP : PH_NAL_FIRST;
					end
					PH_PPS_CNT: phase_d = PH_PPS_HI;
					PH_PPS_HI: begin
						acc_d = {24'd0, in_byte};
						phase_d = PH_PPS_LO;
					end
					PH_PPS_LO: begin
						acc_d = {16'd0, acc_q[7:0], in_byte};
						res.bytes[3] = 8'd1;
						res.count = von_q ? fesd_pkg::CntW'(4) : '0;
						run_d = acc_d;
						phase_d = (acc_d != '0) ? PH_PPS_BODY : PH_SKIP;
					end
					PH_NAL_FIRST: begin
						if (remain <= {21'd0, nsb_q}) phase_d = PH_SKIP;
						else begin
							acc_d = {24'd0, in_byte};
							run_d = {29'd0, nsb_q - 3'd1};
							phase_d = PH_NAL_MORE;
							nal_len = acc_d;
							nal_done = (nsb_q == 3'd1);
						end
					end
					PH_NAL_MORE: begin
						acc_d = {acc_q[23:0], in_byte};
						run_d = run_dec;
						nal_len = acc_d;
						nal_done = (run_dec == '0);
					end
					PH_V_RAW: begin
						res.bytes[0] = in_byte;
						res.count = fesd_pkg::CntW'(von_q);
					end
					default: ;
				endcase
				if (nal_done) begin
					res.bytes[3] = 8'd1;
					res.count = von_q ? fesd_pkg::CntW'(4) : '0;
					run_d = nal_len;
					phase_d = (nal_len != '0) ? PH_NAL_BODY : PH_NAL_FIRST;
				end
				tbc_d = tbc_inc;
				if (tbc_inc >= psize_q) begin
					tbc_d = '0;
					phase_d = PH_THDR;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG0;
			tbc_q   <= '0;
			kind_q  <= '0;
			psize_q <= '0;
			aon_q   <= 1'b0;
			von_q   <= 1'b0;
			asc_q   <= '0;
			nsb_q   <= 3'd4;
			acc_q   <= '0;
			run_q   <= '0;
		end else if (in_take) begin
			phase_q <= phase_d;
			tbc_q   <= tbc_d;
			kind_q  <= kind_d;
			psize_q <= psize_d;
			aon_q   <= aon_d;
			von_q   <= von_d;
			asc_q   <= asc_d;
			nsb_q   <= nsb_d;
			acc_q   <= acc_d;
			run_q   <= run_d;
		end
	end

endmodule

// ===== hdl/fesd_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesd_emitter
// Result register: holds one byte's results and sends one a cycle when taken.
// ----------------------------------------------------------------------------
module fesd_emitter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  fesd_pkg::res_t res,
	output logic           busy,
	output logic           at_last,
	input  logic           out_take,
	output logic [7:0]     out_byte,
	output logic           out_stream,
	output logic           out_error
);

	logic [fesd_pkg::MaxRes-1:0][7:0] bytes_q;
	logic [fesd_pkg::CntW-1:0]        cnt_q;
	logic [fesd_pkg::IdxW-1:0]        idx_q;
	logic                             stream_q, error_q, busy_q;

	assign busy       = busy_q;
	assign at_last    = (idx_q == fesd_pkg::IdxW'(cnt_q - 1'b1));
	assign out_byte   = bytes_q[idx_q];
	assign out_stream = stream_q;
	assign out_error  = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (out_take) begin
				idx_q <= idx_q + 1'b1;
				if (at_last) busy_q <= 1'b0;
			end
			if (load) begin
				busy_q <= (res.count != '0);
				cnt_q  <= res.count;
				idx_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= res.bytes;
			stream_q <= res.stream;
			error_q  <= res.error;
		end
	end

endmodule

// ===== hdl/flv_elementary_stream_demux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_elementary_stream_demux
// FLV demultiplexer to ADTS audio and start-code video byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the FLV file, one byte per transaction in tdata.
//   m_axis carries result bytes; tuser marks the stream (audio or video) and
//   the bad-signature error, tlast marks the final result of one input byte.
//   An input byte is parsed in the cycle it is taken; its results (0 to 7)
//   appear in the result register the next cycle, one transaction a cycle
//   while the receiver takes them. Bytes that cause no result or one result
//   flow at one byte per cycle while the receiver keeps up. A byte that
//   causes n results (ADTS header 7, start code 4) keeps s_axis_tready low
//   until the cycle its last result goes, when the next byte is taken.
//   If the receiver stalls, the result register holds and s_axis stops once
//   the pending results cannot leave.
//   Reset clears the parser to expect the signature; no init is needed.
// ----------------------------------------------------------------------------
module flv_elementary_stream_demux (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] out_stream, [1] out_error
	output logic       m_axis_tlast
);

	fesd_pkg::res_t res;
	logic busy, at_last, in_take, out_take, out_stream, out_error;

	assign out_take      = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = !busy || (m_axis_tready && at_last);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = busy;
	assign m_axis_tlast  = at_last;
	assign m_axis_tuser  = {out_error, out_stream};

	fesd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_take (in_take),
		.in_byte (s_axis_tdata),
		.res     (res)
	);

	fesd_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_take),
		.res        (res),
		.busy       (busy),
		.at_last    (at_last),
		.out_take   (out_take),
		.out_byte   (m_axis_tdata),
		.out_stream (out_stream),
		.out_error  (out_error)
	);

`ifndef ASSERT_OFF
	// pending results block new input unless the final one leaves now
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && busy |-> out_take && at_last)
		else $error("input taken while results pending");
	// error result stands alone and carries zero data
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && m_axis_tdata == 8'd0)
		else $error("malformed error result");
	// the result register empties only after its last transaction
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !in_take && out_take && !at_last |=> busy)
		else $error("results lost");
`endif

endmodule
